// ----- rtl/rmj_pkg.sv -----
// shared types, widths and helpers for the radar measurement jacobian
// no dependencies; used by every module of the block
`default_nettype none

package rmj_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int FLOOR_WIDTH = 17;
  localparam int FLOOR_RESET = 7;
  // input register, two multiply/sum stages, root cells, clamp stage,
  // four scaling stages, divider cells, output register
  localparam int LATENCY     = 2 * WORD_WIDTH + 9;

  typedef logic [WORD_WIDTH-1:0]   word_t;
  typedef logic [2*WORD_WIDTH-1:0] dword_t;
  typedef logic [3*WORD_WIDTH-1:0] tword_t;
  typedef logic [FLOOR_WIDTH-1:0]  floor_t;

  // one stage of the square root row, with the payload that rides along
  typedef struct packed {
    dword_t                rad;
    logic [WORD_WIDTH+1:0] rem;
    word_t                 root;
    word_t                 mpx;
    word_t                 mpy;
    logic                  spx;
    logic                  spy;
    dword_t                d;
    logic                  sd;
  } sqrt_stage_t;

  // one stage of the divider row: six quotients against three divisors
  typedef struct packed {
    logic [5:0]   neg;
    logic [5:0]   ovf;
    logic         clamped;
    word_t        den1;
    dword_t       den2;
    tword_t       den3;
    word_t [1:0]  rem1;
    dword_t [1:0] rem2;
    tword_t [1:0] rem3;
    word_t [5:0]  low;
    word_t [5:0]  quo;
  } div_stage_t;

  function automatic word_t mag_of(input word_t x);
    return x[WORD_WIDTH-1] ? word_t'((~x) + word_t'(1)) : x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rmj_sqrt_cell.sv -----
// one cell of the square root row: resolves one root bit per cycle
// depends on rmj_pkg
`default_nettype none

module rmj_sqrt_cell import rmj_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  sqrt_stage_t in_stage,
  output logic        out_valid,
  output sqrt_stage_t out_stage
);

  logic        valid_r;
  sqrt_stage_t stage_r;
  sqrt_stage_t stage_nxt;
  logic [WORD_WIDTH+1:0] rem_sh;
  logic [WORD_WIDTH+1:0] trial;
  logic                  ge;

  always_comb begin
    rem_sh    = {in_stage.rem[WORD_WIDTH-1:0], in_stage.rad[2*WORD_WIDTH-1 -: 2]};
    trial     = {in_stage.root, 2'b01};
    ge        = (rem_sh >= trial);
    stage_nxt = in_stage;
    stage_nxt.rad  = in_stage.rad << 2;
    stage_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    stage_nxt.root = {in_stage.root[WORD_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire

// ----- rtl/rmj_div_cell.sv -----
// one cell of the divider row: one quotient bit of all six partials per cycle
// depends on rmj_pkg
`default_nettype none

module rmj_div_cell import rmj_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  div_stage_t in_stage,
  output logic       out_valid,
  output div_stage_t out_stage
);

  logic       valid_r;
  div_stage_t stage_r;
  div_stage_t stage_nxt;

  always_comb begin : step
    logic [WORD_WIDTH:0]   a1, f1;
    logic [2*WORD_WIDTH:0] a2, f2;
    logic [3*WORD_WIDTH:0] a3, f3;
    logic [5:0]            qb;
    stage_nxt = in_stage;
    qb = '0;
    for (int i = 0; i < 2; i++) begin
      a1 = {in_stage.rem1[i], in_stage.low[i][WORD_WIDTH-1]};
      f1 = a1 - {1'b0, in_stage.den1};
      qb[i] = (a1 >= {1'b0, in_stage.den1});
      stage_nxt.rem1[i] = qb[i] ? f1[WORD_WIDTH-1:0] : a1[WORD_WIDTH-1:0];

      a2 = {in_stage.rem2[i], in_stage.low[i+2][WORD_WIDTH-1]};
      f2 = a2 - {1'b0, in_stage.den2};
      qb[i+2] = (a2 >= {1'b0, in_stage.den2});
      stage_nxt.rem2[i] = qb[i+2] ? f2[2*WORD_WIDTH-1:0] : a2[2*WORD_WIDTH-1:0];

      a3 = {in_stage.rem3[i], in_stage.low[i+4][WORD_WIDTH-1]};
      f3 = a3 - {1'b0, in_stage.den3};
      qb[i+4] = (a3 >= {1'b0, in_stage.den3});
      stage_nxt.rem3[i] = qb[i+4] ? f3[3*WORD_WIDTH-1:0] : a3[3*WORD_WIDTH-1:0];
    end
    for (int k = 0; k < 6; k++) begin
      stage_nxt.low[k] = in_stage.low[k] << 1;
      stage_nxt.quo[k] = {in_stage.quo[k][WORD_WIDTH-2:0], qb[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire

// ----- rtl/radar_measurement_jacobian.sv -----
// radar measurement jacobian: range, bearing and range-rate partials
// depends on rmj_pkg, rmj_sqrt_cell, rmj_div_cell
`default_nettype none

// usage
//  - a request (pos_x, pos_y, vel_x, vel_y, signed Q16.16) is taken at a
//    clock edge with start high and busy low
//  - busy is high only while rst_n is low and the cycle after; otherwise a
//    new request may be issued on every cycle
//  - each request yields one result, shown for exactly one cycle with
//    out_valid high
//  - throughput is one request per cycle while busy is low; the row of 32
//    square root cells is followed by the row of 32 divider cells, one bit each
//  - results leave in request order; the receiver cannot hold them off
//  - cfg_wr_en/cfg_wr_data write the range floor (Q16.16, 17 bits); a floor
//    of zero acts as one lsb; write only while no request is in flight
//  - reset clears all valid bits and sets the floor to 7

module radar_measurement_jacobian import rmj_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  [WORD_WIDTH-1:0]  in_pos_x,
  input  wire  [WORD_WIDTH-1:0]  in_pos_y,
  input  wire  [WORD_WIDTH-1:0]  in_vel_x,
  input  wire  [WORD_WIDTH-1:0]  in_vel_y,
  input  wire               cfg_wr_en,
  input  wire  [FLOOR_WIDTH-1:0] cfg_wr_data,
  output logic              out_valid,
  output logic [WORD_WIDTH-1:0]  out_drange_dpx,
  output logic [WORD_WIDTH-1:0]  out_drange_dpy,
  output logic [WORD_WIDTH-1:0]  out_dbearing_dpx,
  output logic [WORD_WIDTH-1:0]  out_dbearing_dpy,
  output logic [WORD_WIDTH-1:0]  out_drate_dpx,
  output logic [WORD_WIDTH-1:0]  out_drate_dpy,
  output logic              out_range_clamped,
  output logic              out_saturated
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;

  // control
  logic   busy_r;
  floor_t floor_r;
  logic   accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      floor_r <= floor_t'(FLOOR_RESET);
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr_en) begin
        floor_r <= cfg_wr_data;
      end
    end
  end

  assign busy = busy_r;

  // stage valids for the scalar pipeline
  logic v0_r, v1_r, v2_r, vc_r, vm1_r, vm2_r, vm3_r, vp_r, vo_r;
  logic sq_done_v;
  logic dv_done_v;

  // stage 0: magnitudes and signs of the request
  word_t s0_mpx_r, s0_mpy_r, s0_mvx_r, s0_mvy_r;
  logic  s0_spx_r, s0_spy_r, s0_svx_r, s0_svy_r;

  always_ff @(posedge clk) begin
    s0_mpx_r <= mag_of(in_pos_x);
    s0_mpy_r <= mag_of(in_pos_y);
    s0_mvx_r <= mag_of(in_vel_x);
    s0_mvy_r <= mag_of(in_vel_y);
    s0_spx_r <= in_pos_x[W-1];
    s0_spy_r <= in_pos_y[W-1];
    s0_svx_r <= in_vel_x[W-1];
    s0_svy_r <= in_vel_y[W-1];
  end

  // stage 1: squares and cross products
  dword_t s1_px2_r, s1_py2_r, s1_t1_r, s1_t2_r;
  word_t  s1_mpx_r, s1_mpy_r;
  logic   s1_spx_r, s1_spy_r, s1_s1_r, s1_s2_r;

  always_ff @(posedge clk) begin
    s1_px2_r <= s0_mpx_r * s0_mpx_r;
    s1_py2_r <= s0_mpy_r * s0_mpy_r;
    s1_t1_r  <= s0_mvx_r * s0_mpy_r;
    s1_t2_r  <= s0_mvy_r * s0_mpx_r;
    s1_mpx_r <= s0_mpx_r;
    s1_mpy_r <= s0_mpy_r;
    s1_spx_r <= s0_spx_r;
    s1_spy_r <= s0_spy_r;
    s1_s1_r  <= s0_svx_r ^ s0_spy_r;
    s1_s2_r  <= s0_svy_r ^ s0_spx_r;
  end

  // stage 2: radicand and d = vx*py - vy*px in sign and magnitude
  sqrt_stage_t sq_in_r;
  sqrt_stage_t sq_in_nxt;

  always_comb begin
    sq_in_nxt      = '0;
    sq_in_nxt.rad  = s1_px2_r + s1_py2_r;
    sq_in_nxt.mpx  = s1_mpx_r;
    sq_in_nxt.mpy  = s1_mpy_r;
    sq_in_nxt.spx  = s1_spx_r;
    sq_in_nxt.spy  = s1_spy_r;
    if (s1_s1_r != s1_s2_r) begin
      sq_in_nxt.d  = s1_t1_r + s1_t2_r;
      sq_in_nxt.sd = s1_s1_r;
    end else if (s1_t1_r >= s1_t2_r) begin
      sq_in_nxt.d  = s1_t1_r - s1_t2_r;
      sq_in_nxt.sd = s1_s1_r;
    end else begin
      sq_in_nxt.d  = s1_t2_r - s1_t1_r;
      sq_in_nxt.sd = !s1_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_in_r <= sq_in_nxt;
  end

  // row of square root cells, one root bit each
  logic        sq_v  [W+1];
  sqrt_stage_t sq_st [W+1];

  assign sq_v[0]  = v2_r;
  assign sq_st[0] = sq_in_r;

  for (genvar g = 0; g < W; g++) begin : g_sqrt
    rmj_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[g]),
      .in_stage  (sq_st[g]),
      .out_valid (sq_v[g+1]),
      .out_stage (sq_st[g+1])
    );
  end

  assign sq_done_v = sq_v[W];

  // clamp stage: raise the range to the floor
  word_t  c_rho_r, c_mpx_r, c_mpy_r;
  logic   c_spx_r, c_spy_r, c_sd_r, c_clamped_r;
  dword_t c_d_r;
  word_t  fl;

  assign fl = (floor_r == '0) ? word_t'(1) : word_t'(floor_r);

  always_ff @(posedge clk) begin
    c_clamped_r <= (sq_st[W].root < fl);
    c_rho_r     <= (sq_st[W].root < fl) ? fl : sq_st[W].root;
    c_mpx_r     <= sq_st[W].mpx;
    c_mpy_r     <= sq_st[W].mpy;
    c_spx_r     <= sq_st[W].spx;
    c_spy_r     <= sq_st[W].spy;
    c_d_r       <= sq_st[W].d;
    c_sd_r      <= sq_st[W].sd;
  end

  // m1: rho squared and the d products split in halves
  dword_t m1_r2_r, m1_pydl_r, m1_pydh_r, m1_pxdl_r, m1_pxdh_r;
  word_t  m1_rho_r, m1_mpx_r, m1_mpy_r;
  logic   m1_spx_r, m1_spy_r, m1_sd_r, m1_clamped_r;

  always_ff @(posedge clk) begin
    m1_r2_r      <= c_rho_r * c_rho_r;
    m1_pydl_r    <= c_mpy_r * c_d_r[W-1:0];
    m1_pydh_r    <= c_mpy_r * c_d_r[2*W-1:W];
    m1_pxdl_r    <= c_mpx_r * c_d_r[W-1:0];
    m1_pxdh_r    <= c_mpx_r * c_d_r[2*W-1:W];
    m1_rho_r     <= c_rho_r;
    m1_mpx_r     <= c_mpx_r;
    m1_mpy_r     <= c_mpy_r;
    m1_spx_r     <= c_spx_r;
    m1_spy_r     <= c_spy_r;
    m1_sd_r      <= c_sd_r;
    m1_clamped_r <= c_clamped_r;
  end

  // m2: rho cubed in halves, d products joined
  dword_t m2_r3l_r, m2_r3h_r, m2_r2_r;
  tword_t m2_pyd_r, m2_pxd_r;
  word_t  m2_rho_r, m2_mpx_r, m2_mpy_r;
  logic   m2_spx_r, m2_spy_r, m2_sd_r, m2_clamped_r;

  always_ff @(posedge clk) begin
    m2_r3l_r     <= m1_r2_r[W-1:0] * m1_rho_r;
    m2_r3h_r     <= m1_r2_r[2*W-1:W] * m1_rho_r;
    m2_pyd_r     <= tword_t'(m1_pydl_r) + {m1_pydh_r, word_t'(0)};
    m2_pxd_r     <= tword_t'(m1_pxdl_r) + {m1_pxdh_r, word_t'(0)};
    m2_r2_r      <= m1_r2_r;
    m2_rho_r     <= m1_rho_r;
    m2_mpx_r     <= m1_mpx_r;
    m2_mpy_r     <= m1_mpy_r;
    m2_spx_r     <= m1_spx_r;
    m2_spy_r     <= m1_spy_r;
    m2_sd_r      <= m1_sd_r;
    m2_clamped_r <= m1_clamped_r;
  end

  // m3: rho cubed joined, quotient signs
  tword_t m3_r3_r, m3_pyd_r, m3_pxd_r;
  dword_t m3_r2_r;
  word_t  m3_rho_r, m3_mpx_r, m3_mpy_r;
  logic [5:0] m3_neg_r;
  logic   m3_clamped_r;

  always_ff @(posedge clk) begin
    m3_r3_r      <= tword_t'(m2_r3l_r) + {m2_r3h_r, word_t'(0)};
    m3_pyd_r     <= m2_pyd_r;
    m3_pxd_r     <= m2_pxd_r;
    m3_r2_r      <= m2_r2_r;
    m3_rho_r     <= m2_rho_r;
    m3_mpx_r     <= m2_mpx_r;
    m3_mpy_r     <= m2_mpy_r;
    m3_clamped_r <= m2_clamped_r;
    m3_neg_r     <= {m2_spx_r == m2_sd_r, m2_spy_r != m2_sd_r,
                     m2_spx_r, !m2_spy_r, m2_spy_r, m2_spx_r};
  end

  // prep: scaled numerators, overflow test and first remainders
  logic [W+F-1:0]   n0, n1;
  logic [W+2*F-1:0] n2, n3;
  logic [3*W+F-1:0] n4, n5;
  div_stage_t       dv_in_nxt;
  div_stage_t       dv_in_r;

  always_comb begin
    n0 = {m3_mpx_r, {F{1'b0}}};
    n1 = {m3_mpy_r, {F{1'b0}}};
    n2 = {m3_mpy_r, {2*F{1'b0}}};
    n3 = {m3_mpx_r, {2*F{1'b0}}};
    n4 = {m3_pyd_r, {F{1'b0}}};
    n5 = {m3_pxd_r, {F{1'b0}}};
    dv_in_nxt         = '0;
    dv_in_nxt.neg     = m3_neg_r;
    dv_in_nxt.clamped = m3_clamped_r;
    dv_in_nxt.den1    = m3_rho_r;
    dv_in_nxt.den2    = m3_r2_r;
    dv_in_nxt.den3    = m3_r3_r;
    dv_in_nxt.rem1[0] = word_t'(n0[W+F-1:W]);
    dv_in_nxt.rem1[1] = word_t'(n1[W+F-1:W]);
    dv_in_nxt.rem2[0] = dword_t'(n2[W+2*F-1:W]);
    dv_in_nxt.rem2[1] = dword_t'(n3[W+2*F-1:W]);
    dv_in_nxt.rem3[0] = tword_t'(n4[3*W+F-1:W]);
    dv_in_nxt.rem3[1] = tword_t'(n5[3*W+F-1:W]);
    dv_in_nxt.low[0]  = n0[W-1:0];
    dv_in_nxt.low[1]  = n1[W-1:0];
    dv_in_nxt.low[2]  = n2[W-1:0];
    dv_in_nxt.low[3]  = n3[W-1:0];
    dv_in_nxt.low[4]  = n4[W-1:0];
    dv_in_nxt.low[5]  = n5[W-1:0];
    // quotient needs more than W bits when the high part reaches the divisor
    dv_in_nxt.ovf[0]  = (word_t'(n0[W+F-1:W]) >= m3_rho_r);
    dv_in_nxt.ovf[1]  = (word_t'(n1[W+F-1:W]) >= m3_rho_r);
    dv_in_nxt.ovf[2]  = (dword_t'(n2[W+2*F-1:W]) >= m3_r2_r);
    dv_in_nxt.ovf[3]  = (dword_t'(n3[W+2*F-1:W]) >= m3_r2_r);
    dv_in_nxt.ovf[4]  = (tword_t'(n4[3*W+F-1:W]) >= m3_r3_r);
    dv_in_nxt.ovf[5]  = (tword_t'(n5[3*W+F-1:W]) >= m3_r3_r);
  end

  always_ff @(posedge clk) begin
    dv_in_r <= dv_in_nxt;
  end

  // row of divider cells, one quotient bit each
  logic       dv_v  [W+1];
  div_stage_t dv_st [W+1];

  assign dv_v[0]  = vp_r;
  assign dv_st[0] = dv_in_r;

  for (genvar g = 0; g < W; g++) begin : g_div
    rmj_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[g]),
      .in_stage  (dv_st[g]),
      .out_valid (dv_v[g+1]),
      .out_stage (dv_st[g+1])
    );
  end

  assign dv_done_v = dv_v[W];

  // output stage: saturate, apply sign
  word_t [5:0] res_nxt;
  logic  [5:0] sat_nxt;
  word_t [5:0] res_r;
  logic        sat_r, clamped_r;

  always_comb begin : finish
    word_t lim, v;
    for (int k = 0; k < 6; k++) begin
      lim = dv_st[W].neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      sat_nxt[k] = dv_st[W].ovf[k] || (dv_st[W].quo[k] > lim);
      v = sat_nxt[k] ? lim : dv_st[W].quo[k];
      res_nxt[k] = dv_st[W].neg[k] ? word_t'((~v) + word_t'(1)) : v;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    sat_r     <= |sat_nxt;
    clamped_r <= dv_st[W].clamped;
  end

  // valid chain of the scalar stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vc_r  <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
      vp_r  <= 1'b0;
      vo_r  <= 1'b0;
    end else begin
      v0_r  <= accept;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      vc_r  <= sq_done_v;
      vm1_r <= vc_r;
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
      vp_r  <= vm3_r;
      vo_r  <= dv_done_v;
    end
  end

  assign out_valid         = vo_r;
  assign out_drange_dpx    = res_r[0];
  assign out_drange_dpy    = res_r[1];
  assign out_dbearing_dpx  = res_r[2];
  assign out_dbearing_dpy  = res_r[3];
  assign out_drate_dpx     = res_r[4];
  assign out_drate_dpy     = res_r[5];
  assign out_range_clamped = clamped_r;
  assign out_saturated     = sat_r;

endmodule

`default_nettype wire

// ----- rtl/rmj_checker.sv -----
// port-level checks for radar_measurement_jacobian, attached by bind
// depends on rmj_pkg
`default_nettype none

module rmj_checker import rmj_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire                  out_valid,
  input wire [WORD_WIDTH-1:0] out_drange_dpx,
  input wire [WORD_WIDTH-1:0] out_dbearing_dpy
);

  // every request comes back after a fixed delay
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("request without result");

  // no result without a request
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // px over rho and px over rho squared share the sign of px
  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drange_dpx[WORD_WIDTH-1] |->
      (out_dbearing_dpy[WORD_WIDTH-1] || out_dbearing_dpy == '0))
    else $error("bearing partial sign mismatch");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_drange_dpx   (out_drange_dpx),
  .out_dbearing_dpy (out_dbearing_dpy)
);

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for radar_measurement_jacobian: drives tracked states,
// predicts every jacobian result in wide integer math and checks each output
// depends on rmj_pkg and the radar_measurement_jacobian rtl
`default_nettype none

module testbench;
  import rmj_pkg::*;

  // one expected jacobian row set
  typedef struct packed {
    word_t drange_dpx;
    word_t drange_dpy;
    word_t dbearing_dpx;
    word_t dbearing_dpy;
    word_t drate_dpx;
    word_t drate_dpy;
    logic  range_clamped;
    logic  saturated;
  } jacobian_t;

  typedef logic [255:0] big_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  word_t  in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic   cfg_wr_en;
  floor_t cfg_wr_data;
  logic   out_valid;
  word_t  out_drange_dpx, out_drange_dpy, out_dbearing_dpx, out_dbearing_dpy;
  word_t  out_drate_dpx, out_drate_dpy;
  logic   out_range_clamped, out_saturated;

  radar_measurement_jacobian uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_drange_dpx(out_drange_dpx), .out_drange_dpy(out_drange_dpy),
    .out_dbearing_dpx(out_dbearing_dpx), .out_dbearing_dpy(out_dbearing_dpy),
    .out_drate_dpx(out_drate_dpx), .out_drate_dpy(out_drate_dpy),
    .out_range_clamped(out_range_clamped), .out_saturated(out_saturated)
  );

  // our copy of the floor register and the queue of pending jacobians
  floor_t    floor_model;
  jacobian_t pending_jacobians[$];
  int        error_count;
  int        requests_sent;
  int        results_checked;
  int        clamped_seen;
  int        saturated_seen;
  int        sender_idle_pct;

  // clock: period 10
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    error_count++;
    if (error_count <= 30)
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
               results_checked);
  endtask

  // magnitude of a signed word
  function automatic big_t magnitude(input word_t x);
    return x[WORD_WIDTH-1] ? big_t'(word_t'(~x + 1'b1)) : big_t'(x);
  endfunction

  // truncating quotient with saturation to the signed word
  function automatic word_t saturating_quotient(input big_t num, input logic neg,
                                                input big_t den, inout logic sat);
    big_t q;
    big_t limit;
    q = num / den;
    limit = neg ? (big_t'(1) << (WORD_WIDTH-1)) : ((big_t'(1) << (WORD_WIDTH-1)) - 1);
    if (q > limit) begin
      q = limit;
      sat = 1'b1;
    end
    return neg ? word_t'(big_t'(0) - q) : word_t'(q);
  endfunction

  // full jacobian of one tracked state under the current floor
  function automatic jacobian_t predict_jacobian(input word_t px_w, input word_t py_w,
                                                 input word_t vx_w, input word_t vy_w);
    jacobian_t j;
    big_t px, py, vx, vy, sq_sum, rho, cand, fl, r2, r3, t1, t2, d;
    logic spx, spy, svx, svy, s1, s2, sd, sat;
    spx = px_w[WORD_WIDTH-1];
    spy = py_w[WORD_WIDTH-1];
    svx = vx_w[WORD_WIDTH-1];
    svy = vy_w[WORD_WIDTH-1];
    px = magnitude(px_w);
    py = magnitude(py_w);
    vx = magnitude(vx_w);
    vy = magnitude(vy_w);
    sq_sum = px * px + py * py;
    // bitwise integer root
    rho = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = rho | (big_t'(1) << b);
      if (cand * cand <= sq_sum)
        rho = cand;
    end
    fl = (floor_model != 0) ? big_t'(floor_model) : big_t'(1);
    j.range_clamped = 1'b0;
    if (rho < fl) begin
      rho = fl;
      j.range_clamped = 1'b1;
    end
    r2 = rho * rho;
    r3 = r2 * rho;
    // cross term vx*py - vy*px held as sign and magnitude
    t1 = vx * py;
    s1 = svx ^ spy;
    t2 = vy * px;
    s2 = svy ^ spx;
    if (s1 != s2) begin
      d = t1 + t2;
      sd = s1;
    end else if (t1 >= t2) begin
      d = t1 - t2;
      sd = s1;
    end else begin
      d = t2 - t1;
      sd = !s1;
    end
    sat = 1'b0;
    j.drange_dpx   = saturating_quotient(px << FRAC_BITS, spx, rho, sat);
    j.drange_dpy   = saturating_quotient(py << FRAC_BITS, spy, rho, sat);
    j.dbearing_dpx = saturating_quotient(py << (2*FRAC_BITS), !spy, r2, sat);
    j.dbearing_dpy = saturating_quotient(px << (2*FRAC_BITS), spx, r2, sat);
    j.drate_dpx    = saturating_quotient((py * d) << FRAC_BITS, spy != sd, r3, sat);
    j.drate_dpy    = saturating_quotient((px * d) << FRAC_BITS, spx == sd, r3, sat);
    j.saturated = sat;
    return j;
  endfunction

  // result checker: every strobe must match the oldest pending jacobian
  always @(posedge clk) begin
    jacobian_t want;
    if (rst_n && out_valid) begin
      results_checked++;
      if (pending_jacobians.size() == 0) begin
        report_mismatch("unexpected result", out_drange_dpx, '0);
      end else begin
        want = pending_jacobians.pop_front();
        if (out_drange_dpx !== want.drange_dpx)
          report_mismatch("drange_dpx", out_drange_dpx, want.drange_dpx);
        if (out_drange_dpy !== want.drange_dpy)
          report_mismatch("drange_dpy", out_drange_dpy, want.drange_dpy);
        if (out_dbearing_dpx !== want.dbearing_dpx)
          report_mismatch("dbearing_dpx", out_dbearing_dpx, want.dbearing_dpx);
        if (out_dbearing_dpy !== want.dbearing_dpy)
          report_mismatch("dbearing_dpy", out_dbearing_dpy, want.dbearing_dpy);
        if (out_drate_dpx !== want.drate_dpx)
          report_mismatch("drate_dpx", out_drate_dpx, want.drate_dpx);
        if (out_drate_dpy !== want.drate_dpy)
          report_mismatch("drate_dpy", out_drate_dpy, want.drate_dpy);
        if (out_range_clamped !== want.range_clamped)
          report_mismatch("range_clamped", word_t'(out_range_clamped),
                          word_t'(want.range_clamped));
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", word_t'(out_saturated), word_t'(want.saturated));
        if (want.range_clamped) clamped_seen++;
        if (want.saturated) saturated_seen++;
      end
    end
  end

  // present one request and hold it until taken; start stays high afterwards
  task automatic send_state(input word_t px, input word_t py, input word_t vx,
                            input word_t vy);
    start    <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    do @(posedge clk); while (busy);
    pending_jacobians.push_back(predict_jacobian(px, py, vx, vy));
    requests_sent++;
  endtask

  // random gap after a request, per the current sender idle rate
  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // lower start and wait until every pending result has come back
  task automatic drain_pipeline();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_jacobians.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // floor writes only with the pipeline empty
  task automatic write_floor(input floor_t value);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    floor_model = value;
  endtask

  // word with a mix of shapes: full random, tiny, extremes, shifted random, moderate q16.16
  function automatic word_t random_coord();
    word_t w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = word_t'($urandom_range(0, 80)) * ($urandom_range(1) ? 1 : -1);
      2: w = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: w = word_t'($urandom >> $urandom_range(0, 31)) * ($urandom_range(1) ? 1 : -1);
      default: w = word_t'($urandom_range(0, 32'h00ffffff)) * ($urandom_range(1) ? 1 : -1);
    endcase
    return w;
  endfunction

  task automatic send_random_states(input int count);
    for (int i = 0; i < count; i++) begin
      send_state(random_coord(), random_coord(), random_coord(), random_coord());
      sender_gap();
    end
  endtask

  // zero state, extremes of each field, clamping at the reset floor
  task automatic test_directed_corners();
    send_state(32'h0, 32'h0, 32'h0, 32'h0);
    send_state(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_state(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_state(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_state(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_state(32'h00000001, 32'h00000000, 32'h00010000, 32'h00000000);
    send_state(32'h00000003, 32'hfffffffc, 32'h00000000, 32'h00010000);
    send_state(32'h00000007, 32'h00000000, 32'hffff0000, 32'h00020000);
    send_state(32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000);
    send_state(32'h00000000, 32'hffff0000, 32'h00010000, 32'h00000000);
    send_state(32'h00030000, 32'h00040000, 32'hfffe0000, 32'h00010000);
    send_state(32'h7fffffff, 32'h00000000, 32'h00000000, 32'h80000000);
    send_state(32'h00000000, 32'h80000000, 32'h7fffffff, 32'h00000000);
    send_state(32'h00000100, 32'hffffff00, 32'h55555555, 32'haaaaaaaa);
  endtask

  // zero floor acts as one lsb
  task automatic test_zero_floor();
    write_floor(floor_t'(0));
    send_state(32'h0, 32'h0, 32'h7fffffff, 32'h80000000);
    send_state(32'h1, 32'h0, 32'h0, 32'h1);
    send_state(32'h0, 32'hffffffff, 32'hffffffff, 32'h0);
    send_random_states(60);
  endtask

  // sweep the floor through its range, including the top of the field
  task automatic test_floor_sweep();
    floor_t floors[6];
    floors = '{floor_t'(1), floor_t'(65536), floor_t'(131071), floor_t'(7),
               floor_t'(300), floor_t'(4096)};
    foreach (floors[k]) begin
      write_floor(floors[k]);
      send_state(32'h0, 32'h0, 32'h00010000, 32'h0);
      send_state(32'h00008000, 32'hffff8000, 32'h00010000, 32'hffff0000);
      send_random_states(80);
    end
  endtask

  // bulk random traffic in three idling phases
  task automatic test_random_traffic();
    int rates[3];
    rates = '{22, 78, 0};
    foreach (rates[k]) begin
      sender_idle_pct = rates[k];
      write_floor(floor_t'($urandom_range(0, 131071)));
      send_random_states(200);
      write_floor(floor_t'($urandom_range(1, 64)));
      send_random_states(200);
    end
  endtask

  initial begin
    int guard;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    floor_model = floor_t'(FLOOR_RESET);
    error_count = 0;
    requests_sent = 0;
    results_checked = 0;
    clamped_seen = 0;
    saturated_seen = 0;
    sender_idle_pct = 22;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_zero_floor();
    test_floor_sweep();
    test_random_traffic();

    // wait for the tail, then watch for strays
    start <= 1'b0;
    guard = 0;
    while (pending_jacobians.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_jacobians.size() != 0)
      report_mismatch("results never arrived", word_t'(pending_jacobians.size()), '0);

    $display("covered %0d requests, %0d results checked, %0d clamped, %0d saturated",
             requests_sent, results_checked, clamped_seen, saturated_seen);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
